[src/wrr_pkg.sv]
package wrr_pkg;

    // fixed field widths
    localparam int TID_W   = 6;
    localparam int WGT_W   = 8;
    localparam int BASE_W  = 10;
    localparam int SLICE_W = 18;
    localparam int SUM_W   = 14;
    localparam int QCNT_W  = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register reset values
    localparam logic [BASE_W-1:0] BASE_SLICE_RST     = 10'd10;
    localparam logic [WGT_W-1:0]  DEFAULT_WEIGHT_RST = 8'd10;

    // register select (word address bit)
    localparam logic REG_BASE_SLICE     = 1'b0;
    localparam logic REG_DEFAULT_WEIGHT = 1'b1;

    // operation codes
    typedef enum logic [2:0] {
        FN_ADMIT    = 3'd0,
        FN_ENQ_TAIL = 3'd1,
        FN_ENQ_HEAD = 3'd2,
        FN_DEQUEUE  = 3'd3,
        FN_TICK     = 3'd4,
        FN_YIELD    = 3'd5,
        FN_PICK     = 3'd6
    } func_e_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
        logic move;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic move_needed;
        logic out_free;
    } sts_t;

endpackage

[src/wrr_ram.sv]
module wrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/wrr_ctrl.sv]
module wrr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  wrr_pkg::sts_t sts,
    output wrr_pkg::cmd_t cmd,
    output logic          in_stall
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_MOVE,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   take_ok;

    always_comb
    begin
        take_ok = (state_reg == ST_IDLE) || ((state_reg == ST_FIN) && sts.out_free);
        cmd.clear_en = (state_reg == ST_CLEAR);
        cmd.accept   = take_ok && in_valid;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.move     = (state_reg == ST_MOVE);
        cmd.load_out = (state_reg == ST_FIN) && sts.out_free;
        in_stall     = !take_ok;

        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = sts.move_needed ? ST_MOVE : ST_FIN;
            end
            ST_MOVE:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = in_valid ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[src/wrr_datapath.sv]
module wrr_datapath #(
    parameter int MAX_TASKS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wrr_pkg::cmd_t                       cmd,
    output wrr_pkg::sts_t                       sts,
    // input item
    input  logic [2:0]                          func,
    input  logic [wrr_pkg::TID_W-1:0]           task_id,
    input  logic [wrr_pkg::WGT_W-1:0]           weight,
    // result item
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                status,
    output logic                                next_valid,
    output logic [wrr_pkg::TID_W-1:0]           next_task,
    output logic                                resched,
    output logic [wrr_pkg::QCNT_W-1:0]          queued_count,
    output logic [wrr_pkg::SUM_W-1:0]           queued_weight,
    output logic [wrr_pkg::SLICE_W-1:0]         slice_left,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wrr_pkg::PADDR_W-1:0]         paddr,
    input  logic [wrr_pkg::PDATA_W-1:0]         pwdata,
    output logic [wrr_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int TW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int WW = wrr_pkg::WGT_W;
    localparam int SW = wrr_pkg::SLICE_W;
    localparam int BW = wrr_pkg::BASE_W;
    localparam int MW = wrr_pkg::SUM_W;

    // configuration
    logic [BW-1:0] base_reg;
    logic [WW-1:0] dflt_reg;

    // captured item
    logic [2:0]                  func_reg;
    logic [wrr_pkg::TID_W-1:0]   tid_reg;
    logic [WW-1:0]               wgt_reg;

    // queue state
    logic [TW-1:0] head_reg, head_next;
    logic [TW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [MW-1:0] sum_reg, sum_next;
    logic [TW-1:0] clr_reg, clr_next;

    // per-item result
    logic          res_status_reg, res_status_next;
    logic          res_resched_reg, res_resched_next;
    logic [SW-1:0] res_slice_reg, res_slice_next;

    // output register
    logic                        out_valid_reg;
    logic                        out_status_reg;
    logic                        out_nvalid_reg;
    logic [wrr_pkg::TID_W-1:0]   out_ntask_reg;
    logic                        out_resched_reg;
    logic [wrr_pkg::QCNT_W-1:0]  out_count_reg;
    logic [MW-1:0]               out_sum_reg;
    logic [SW-1:0]               out_slice_reg;

    // tables
    logic          nx_we, pv_we, wt_we, sl_we, iq_we;
    logic [TW-1:0] nx_waddr, pv_waddr, iq_waddr;
    logic [TW-1:0] nx_wdata, pv_wdata;
    logic [WW-1:0] wt_wdata;
    logic [SW-1:0] sl_wdata;
    logic [0:0]    iq_wdata;
    logic [TW-1:0] nx_rdata, pv_rdata;
    logic [WW-1:0] wt_rdata;
    logic [SW-1:0] sl_rdata;
    logic [0:0]    iq_rdata;
    logic [TW-1:0] rd_idx, sl_raddr;

    // execute decode
    wrr_pkg::func_e_t fn;
    logic [TW-1:0]    t_idx;
    logic             valid_task;
    logic             qd, is_head, is_tail, has_many, expire, move_cond;
    logic [WW-1:0]    nw, mult_a;
    logic [SW-1:0]    product;
    logic             cfg_wr;

    // item index into the tables; the port read is launched at accept
    assign rd_idx   = TW'(task_id);
    assign sl_raddr = (func == wrr_pkg::FN_PICK) ? head_reg : rd_idx;

    wrr_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(rd_idx), .rdata(nx_rdata)
    );
    wrr_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(rd_idx), .rdata(pv_rdata)
    );
    wrr_ram #(.WIDTH(WW), .DEPTH(MAX_TASKS)) u_weight_ram (
        .clk(clk), .we(wt_we), .waddr(t_idx), .wdata(wt_wdata),
        .raddr(rd_idx), .rdata(wt_rdata)
    );
    wrr_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_slice_ram (
        .clk(clk), .we(sl_we), .waddr(t_idx), .wdata(sl_wdata),
        .raddr(sl_raddr), .rdata(sl_rdata)
    );
    wrr_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_inq_ram (
        .clk(clk), .we(iq_we), .waddr(iq_waddr), .wdata(iq_wdata),
        .raddr(rd_idx), .rdata(iq_rdata)
    );

    always_comb
    begin
        fn         = wrr_pkg::func_e_t'(func_reg);
        t_idx      = TW'(tid_reg);
        valid_task = (32'(tid_reg) < 32'(MAX_TASKS));
        qd         = iq_rdata[0];
        is_head    = (t_idx == head_reg);
        is_tail    = (t_idx == tail_reg);
        has_many   = (count_reg > CW'(1));
        expire     = (sl_rdata <= SW'(1));
        nw         = (wgt_reg == '0) ? dflt_reg : wgt_reg;
        mult_a     = (fn == wrr_pkg::FN_ADMIT) ? nw : wt_rdata;
        product    = {{(SW-WW){1'b0}}, mult_a} * {{(SW-BW){1'b0}}, base_reg};
        move_cond  = valid_task && qd && has_many && !is_tail &&
                     (((fn == wrr_pkg::FN_TICK) && expire) || (fn == wrr_pkg::FN_YIELD));

        nx_we    = 1'b0;
        nx_waddr = t_idx;
        nx_wdata = head_reg;
        pv_we    = 1'b0;
        pv_waddr = t_idx;
        pv_wdata = tail_reg;
        wt_we    = 1'b0;
        wt_wdata = nw;
        sl_we    = 1'b0;
        sl_wdata = product;
        iq_we    = 1'b0;
        iq_waddr = t_idx;
        iq_wdata = 1'b0;

        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        clr_next         = clr_reg;
        res_status_next  = res_status_reg;
        res_resched_next = res_resched_reg;
        res_slice_next   = res_slice_reg;

        if (cmd.clear_en)
        begin
            iq_we    = 1'b1;
            iq_waddr = clr_reg;
            clr_next = clr_reg + TW'(1);
        end

        if (cmd.exec)
        begin
            res_status_next  = 1'b0;
            res_resched_next = 1'b0;
            res_slice_next   = valid_task ? sl_rdata : '0;
            if (!valid_task)
            begin
                res_status_next = 1'b1;
            end
            else
            begin
                unique case (fn)
                    wrr_pkg::FN_ADMIT:
                    begin
                        wt_we          = 1'b1;
                        sl_we          = 1'b1;
                        res_slice_next = product;
                        if (qd)
                        begin
                            sum_next = sum_reg - MW'(wt_rdata) + MW'(nw);
                        end
                    end
                    wrr_pkg::FN_ENQ_TAIL, wrr_pkg::FN_ENQ_HEAD:
                    begin
                        if (qd)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            iq_we      = 1'b1;
                            iq_wdata   = 1'b1;
                            count_next = count_reg + CW'(1);
                            sum_next   = sum_reg + MW'(wt_rdata);
                            if (count_reg == '0)
                            begin
                                head_next = t_idx;
                                tail_next = t_idx;
                            end
                            else if (fn == wrr_pkg::FN_ENQ_HEAD)
                            begin
                                // new head points forward at the old head
                                nx_we     = 1'b1;
                                nx_waddr  = t_idx;
                                nx_wdata  = head_reg;
                                pv_we     = 1'b1;
                                pv_waddr  = head_reg;
                                pv_wdata  = t_idx;
                                head_next = t_idx;
                            end
                            else
                            begin
                                pv_we     = 1'b1;
                                pv_waddr  = t_idx;
                                pv_wdata  = tail_reg;
                                nx_we     = 1'b1;
                                nx_waddr  = tail_reg;
                                nx_wdata  = t_idx;
                                tail_next = t_idx;
                            end
                        end
                    end
                    wrr_pkg::FN_DEQUEUE:
                    begin
                        if (!qd)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            iq_we      = 1'b1;
                            iq_wdata   = 1'b0;
                            count_next = count_reg - CW'(1);
                            sum_next   = sum_reg - MW'(wt_rdata);
                            if (is_head)
                            begin
                                head_next = nx_rdata;
                            end
                            else
                            begin
                                nx_we    = 1'b1;
                                nx_waddr = pv_rdata;
                                nx_wdata = nx_rdata;
                            end
                            if (is_tail)
                            begin
                                tail_next = pv_rdata;
                            end
                            else
                            begin
                                pv_we    = 1'b1;
                                pv_waddr = nx_rdata;
                                pv_wdata = pv_rdata;
                            end
                        end
                    end
                    wrr_pkg::FN_TICK, wrr_pkg::FN_YIELD:
                    begin
                        if (fn == wrr_pkg::FN_TICK)
                        begin
                            sl_we = 1'b1;
                            if (expire)
                            begin
                                sl_wdata       = product;
                                res_slice_next = product;
                                res_resched_next = qd && has_many;
                            end
                            else
                            begin
                                sl_wdata       = sl_rdata - SW'(1);
                                res_slice_next = sl_rdata - SW'(1);
                            end
                        end
                        else if (!qd)
                        begin
                            res_status_next = 1'b1;
                        end
                        // unlink now, relink at the tail in the move step
                        if (move_cond)
                        begin
                            if (is_head)
                            begin
                                head_next = nx_rdata;
                            end
                            else
                            begin
                                nx_we    = 1'b1;
                                nx_waddr = pv_rdata;
                                nx_wdata = nx_rdata;
                            end
                            pv_we    = 1'b1;
                            pv_waddr = nx_rdata;
                            pv_wdata = pv_rdata;
                        end
                    end
                    wrr_pkg::FN_PICK:
                    begin
                        res_status_next = 1'b0;
                    end
                    default:
                    begin
                        res_status_next = 1'b1;
                    end
                endcase
            end
            if (fn == wrr_pkg::FN_PICK)
            begin
                res_slice_next = (count_reg != '0) ? sl_rdata : '0;
            end
        end

        if (cmd.move)
        begin
            pv_we     = 1'b1;
            pv_waddr  = t_idx;
            pv_wdata  = tail_reg;
            nx_we     = 1'b1;
            nx_waddr  = tail_reg;
            nx_wdata  = t_idx;
            tail_next = t_idx;
        end

        sts.clear_last  = (clr_reg == TW'(MAX_TASKS - 1));
        sts.move_needed = move_cond;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    // register port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            wrr_pkg::REG_BASE_SLICE:     prdata = wrr_pkg::PDATA_W'(base_reg);
            wrr_pkg::REG_DEFAULT_WEIGHT: prdata = wrr_pkg::PDATA_W'(dflt_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= wrr_pkg::BASE_SLICE_RST;
            dflt_reg        <= wrr_pkg::DEFAULT_WEIGHT_RST;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            sum_reg         <= '0;
            clr_reg         <= '0;
            res_status_reg  <= 1'b0;
            res_resched_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == wrr_pkg::REG_BASE_SLICE)
                begin
                    base_reg <= pwdata[BW-1:0];
                end
                else
                begin
                    dflt_reg <= pwdata[WW-1:0];
                end
            end
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            sum_reg         <= sum_next;
            clr_reg         <= clr_next;
            res_status_reg  <= res_status_next;
            res_resched_reg <= res_resched_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_slice_reg <= res_slice_next;
        if (cmd.accept)
        begin
            func_reg <= func;
            tid_reg  <= task_id;
            wgt_reg  <= weight;
        end
        if (cmd.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_nvalid_reg  <= (count_reg != '0);
            out_ntask_reg   <= (count_reg != '0) ? wrr_pkg::TID_W'(head_reg) : '0;
            out_resched_reg <= res_resched_reg;
            out_count_reg   <= wrr_pkg::QCNT_W'(count_reg);
            out_sum_reg     <= sum_reg;
            out_slice_reg   <= res_slice_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign next_valid    = out_nvalid_reg;
    assign next_task     = out_ntask_reg;
    assign resched       = out_resched_reg;
    assign queued_count  = out_count_reg;
    assign queued_weight = out_sum_reg;
    assign slice_left    = out_slice_reg;

endmodule

[src/weighted_round_robin_run_queue_core.sv]
// sequence: accept, execute, a move step when a tick or yield requeues the task, result load;
//   a new item is taken only once the previous result loads; the table read is registered,
//   so an item executes the cycle after accept; a requeue adds the move step since each link
//   table has a single write port and is written twice
// reset: asynchronous, active low; queue empty, registers at their defaults, then an
//   in-queue clearing pass of MAX_TASKS entries, input stalled (register port stays live)
module weighted_round_robin_run_queue_core #(
    parameter int MAX_TASKS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input item channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  func,
    input  logic [wrr_pkg::TID_W-1:0]   task_id,
    input  logic [wrr_pkg::WGT_W-1:0]   weight,
    // result item channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        status,
    output logic                        next_valid,
    output logic [wrr_pkg::TID_W-1:0]   next_task,
    output logic                        resched,
    output logic [wrr_pkg::QCNT_W-1:0]  queued_count,
    output logic [wrr_pkg::SUM_W-1:0]   queued_weight,
    output logic [wrr_pkg::SLICE_W-1:0] slice_left,
    // register port: base_slice at 0x0, default_weight at 0x4
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wrr_pkg::PADDR_W-1:0] paddr,
    input  logic [wrr_pkg::PDATA_W-1:0] pwdata,
    output logic [wrr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    // command and status between sequencer and datapath
    wrr_pkg::cmd_t cmd;
    wrr_pkg::sts_t sts;

    // sequencer: clear pass, accept, execute, optional tail relink, result load;
    // a new item is taken in the same cycle that the previous result loads
    wrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // datapath: link, weight, slice and in-queue tables read at accept,
    // updated in the execute step; head, tail, count and weight sum in flops;
    // one slice multiplier shared by admit and the tick reload;
    // output register lets the next item run while a result waits
    wrr_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .task_id       (task_id),
        .weight        (weight),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .next_valid    (next_valid),
        .next_task     (next_task),
        .resched       (resched),
        .queued_count  (queued_count),
        .queued_weight (queued_weight),
        .slice_left    (slice_left),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

endmodule

[test/tb_weighted_round_robin_run_queue_core.sv]
`timescale 1ns / 1ps

module tb_weighted_round_robin_run_queue_core;

    import wrr_pkg::*;

    // code the block does not define, answered with status 1
    localparam logic [2:0] FN_UNUSED = 3'd7;

    // cycles to let pass after the last result before touching registers or ending
    localparam int SETTLE_CYCLES = 8;
    // cycles with work outstanding but no item moving on either channel
    localparam int STUCK_LIMIT = 5000;

    // one result item as the block reports it
    typedef struct packed {
        logic                st;
        logic                nv;
        logic [TID_W-1:0]    nt;
        logic                rs;
        logic [QCNT_W-1:0]   cnt;
        logic [SUM_W-1:0]    wsum;
        logic [SLICE_W-1:0]  sl;
    } sched_result_t;

    // one input item plus how it is to be presented
    typedef struct packed {
        logic [2:0]          fn;
        logic [TID_W-1:0]    tid;
        logic [WGT_W-1:0]    wgt;
        logic                typed;   // want below is typed in, not predicted
        sched_result_t       want;
        logic [7:0]          gap;     // idle cycles after this item is taken
        logic                burst;   // no idling on either side around this item
    } sched_op_t;

    // directed row: either an item or a register write
    typedef struct packed {
        logic                is_cfg;
        logic                reg_sel;
        logic [PDATA_W-1:0]  reg_val;
        sched_op_t           op;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           func = '0;
    logic [TID_W-1:0]     task_id = '0;
    logic [WGT_W-1:0]     weight = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 status;
    logic                 next_valid;
    logic [TID_W-1:0]     next_task;
    logic                 resched;
    logic [QCNT_W-1:0]    queued_count;
    logic [SUM_W-1:0]     queued_weight;
    logic [SLICE_W-1:0]   slice_left;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    weighted_round_robin_run_queue_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .task_id       (task_id),
        .weight        (weight),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .next_valid    (next_valid),
        .next_task     (next_task),
        .resched       (resched),
        .queued_count  (queued_count),
        .queued_weight (queued_weight),
        .slice_left    (slice_left),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // run queue shadow: links, membership, weights, slices, head/tail
    // ------------------------------------------------------------------
    logic [BASE_W-1:0]   cfg_base = BASE_SLICE_RST;
    logic [WGT_W-1:0]    cfg_defw = DEFAULT_WEIGHT_RST;

    logic [TID_W-1:0]    rq_next   [64];
    logic [TID_W-1:0]    rq_prev   [64];
    bit                  rq_member [64];
    logic [WGT_W-1:0]    rq_weight [64];
    logic [SLICE_W-1:0]  rq_slice  [64];
    logic [TID_W-1:0]    rq_head = '0;
    logic [TID_W-1:0]    rq_tail = '0;
    logic [QCNT_W-1:0]   rq_count = '0;
    logic [SUM_W-1:0]    rq_wsum = '0;

    // tasks admitted so far, as seen by the stimulus generator
    bit                  gen_admitted [64];

    // pending stimulus, and results owed by the block in order
    sched_op_t           stim_q [$];
    sched_result_t       sched_want_q [$];

    int                  items_issued = 0;
    int                  results_seen = 0;
    int                  err_count = 0;

    function automatic logic [SLICE_W-1:0] full_slice(logic [WGT_W-1:0] w);
        logic [SLICE_W-1:0] p;
        p = w * cfg_base;
        return p;
    endfunction

    // link at one end; count and sum are left to the caller
    function automatic void rq_link(logic [TID_W-1:0] t, bit at_head);
        if (rq_count == 0)
        begin
            rq_head = t;
            rq_tail = t;
        end
        else if (at_head)
        begin
            rq_next[t] = rq_head;
            rq_prev[rq_head] = t;
            rq_head = t;
        end
        else
        begin
            rq_prev[t] = rq_tail;
            rq_next[rq_tail] = t;
            rq_tail = t;
        end
    endfunction

    function automatic void rq_unlink(logic [TID_W-1:0] t);
        logic [TID_W-1:0] p;
        logic [TID_W-1:0] n;
        p = rq_prev[t];
        n = rq_next[t];
        if (t == rq_head)
            rq_head = n;
        else
            rq_next[p] = n;
        if (t == rq_tail)
            rq_tail = p;
        else
            rq_prev[n] = p;
    endfunction

    function automatic void rq_to_tail(logic [TID_W-1:0] t);
        if (rq_count > 1 && t != rq_tail)
        begin
            rq_unlink(t);
            rq_link(t, 1'b0);
        end
    endfunction

    // apply one item to the shadow queue and return the result it causes
    function automatic sched_result_t predict_sched(logic [2:0] fn, logic [TID_W-1:0] t,
                                                    logic [WGT_W-1:0] w);
        sched_result_t r;
        logic [WGT_W-1:0] nw;
        r = '0;
        case (fn)
            FN_ADMIT:
            begin
                nw = (w == 0) ? cfg_defw : w;
                // re-admit of a queued task keeps the sum equal to the queued weights
                if (rq_member[t])
                    rq_wsum = rq_wsum - rq_weight[t] + nw;
                rq_weight[t] = nw;
                rq_slice[t] = full_slice(nw);
            end
            FN_ENQ_TAIL, FN_ENQ_HEAD:
            begin
                if (rq_member[t])
                    r.st = 1'b1;
                else
                begin
                    rq_link(t, fn == FN_ENQ_HEAD);
                    rq_member[t] = 1'b1;
                    rq_count = rq_count + 1;
                    rq_wsum = rq_wsum + rq_weight[t];
                end
            end
            FN_DEQUEUE:
            begin
                if (!rq_member[t])
                    r.st = 1'b1;
                else
                begin
                    rq_unlink(t);
                    rq_member[t] = 1'b0;
                    rq_count = rq_count - 1;
                    rq_wsum = rq_wsum - rq_weight[t];
                end
            end
            FN_TICK:
            begin
                // slice of one or zero expires without wrapping
                if (rq_slice[t] > 1)
                    rq_slice[t] = rq_slice[t] - 1;
                else
                begin
                    rq_slice[t] = full_slice(rq_weight[t]);
                    if (rq_member[t] && rq_count > 1)
                    begin
                        rq_to_tail(t);
                        r.rs = 1'b1;
                    end
                end
            end
            FN_YIELD:
            begin
                if (!rq_member[t])
                    r.st = 1'b1;
                else
                    rq_to_tail(t);
            end
            FN_PICK:
            begin
            end
            default:
                r.st = 1'b1;
        endcase
        if (fn == FN_PICK)
            r.sl = (rq_count != 0) ? rq_slice[rq_head] : '0;
        else
            r.sl = rq_slice[t];
        r.nv   = (rq_count != 0);
        r.nt   = (rq_count != 0) ? rq_head : '0;
        r.cnt  = rq_count;
        r.wsum = rq_wsum;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // helpers for stimulus
    // ------------------------------------------------------------------

    // idle length: mostly none, often short, now and then long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic sched_result_t row_want(int st, int nv, int nt, int rs, int cnt,
                                               int wsum, int sl);
        sched_result_t r;
        r.st   = st[0];
        r.nv   = nv[0];
        r.nt   = nt[TID_W-1:0];
        r.rs   = rs[0];
        r.cnt  = cnt[QCNT_W-1:0];
        r.wsum = wsum[SUM_W-1:0];
        r.sl   = sl[SLICE_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t row_op(logic [2:0] fn, int t, int w);
        dir_row_t d;
        d = '0;
        d.op.fn  = fn;
        d.op.tid = t[TID_W-1:0];
        d.op.wgt = w[WGT_W-1:0];
        return d;
    endfunction

    function automatic dir_row_t row_chk(logic [2:0] fn, int t, int w, sched_result_t want);
        dir_row_t d;
        d = row_op(fn, t, w);
        d.op.typed = 1'b1;
        d.op.want  = want;
        return d;
    endfunction

    function automatic dir_row_t row_cfg(logic sel, int val);
        dir_row_t d;
        d = '0;
        d.is_cfg  = 1'b1;
        d.reg_sel = sel;
        d.reg_val = val;
        return d;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic push_item(input sched_op_t it);
        if (it.fn == FN_ADMIT)
            gen_admitted[it.tid] = 1'b1;
        stim_q.push_back(it);
        items_issued++;
    endtask

    // block is drained: every result owed has come, then the SETTLE_CYCLES wait
    task automatic wait_idle();
        while (results_seen < items_issued)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write: setup cycle, then access cycle; pready is always high
    task automatic apb_write(input logic sel, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_BASE_SLICE)
            cfg_base = val[BASE_W-1:0];
        else
            cfg_defw = val[WGT_W-1:0];
    endtask

    // one random phase: set both registers, then n items over a pool of tasks
    task automatic run_phase(input int base, input int defw, input int pool, input bit heavy,
                             input int n);
        sched_op_t it;
        int r;
        int k;
        int burst_left;
        int enq_w;
        int deq_w;
        wait_idle();
        apb_write(REG_BASE_SLICE, base);
        apb_write(REG_DEFAULT_WEIGHT, defw);
        burst_left = 0;
        // fill-heavy phases push the queue towards all tasks queued
        enq_w = heavy ? 30 : 18;
        deq_w = heavy ? 6 : 14;
        for (k = 0; k < n; k++)
        begin
            it = '0;
            if (burst_left > 0)
                burst_left--;
            else if ($urandom_range(0, 19) == 0)
                burst_left = $urandom_range(10, 40);
            it.tid = $urandom_range(0, pool - 1);
            r = $urandom_range(0, 99);
            if (r < 12)
                it.fn = FN_ADMIT;
            else if (r < 12 + enq_w)
                it.fn = FN_ENQ_TAIL;
            else if (r < 20 + enq_w)
                it.fn = FN_ENQ_HEAD;
            else if (r < 20 + enq_w + deq_w)
                it.fn = FN_DEQUEUE;
            else if (r < 28 + enq_w + deq_w)
                it.fn = FN_YIELD;
            else if (r < 32 + enq_w + deq_w)
                it.fn = FN_PICK;
            else if (r < 34 + enq_w + deq_w)
                it.fn = FN_UNUSED;
            else
                it.fn = FN_TICK;
            // never touch the weight or slice of a task not yet admitted
            if (it.fn != FN_ADMIT && it.fn != FN_PICK && !gen_admitted[it.tid])
                it.fn = FN_ADMIT;
            r = $urandom_range(0, 9);
            if (r < 2)
                it.wgt = '0;
            else if (r < 6)
                it.wgt = $urandom_range(1, 4);
            else
                it.wgt = $urandom_range(0, 255);
            it.burst = (burst_left > 0);
            it.gap = it.burst ? 0 : rand_gap();
            push_item(it);
        end
    endtask

    // ------------------------------------------------------------------
    // input side: present items, predict at the edge where one is taken
    // ------------------------------------------------------------------
    sched_op_t      cur_op;
    sched_result_t  pred_r;
    int             gap_left = 0;
    bit             burst_now = 1'b0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                // shadow state follows acceptance order
                pred_r = predict_sched(cur_op.fn, cur_op.tid, cur_op.wgt);
                sched_want_q.push_back(cur_op.typed ? cur_op.want : pred_r);
            end
            // a stalled item holds still; otherwise idle or present the next
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (stim_q.size() != 0)
                begin
                    cur_op = stim_q.pop_front();
                    func      <= cur_op.fn;
                    task_id   <= cur_op.tid;
                    weight    <= cur_op.wgt;
                    in_valid  <= 1'b1;
                    gap_left  = cur_op.gap;
                    burst_now = cur_op.burst;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: random stall, compare each item with the oldest expectation
    // ------------------------------------------------------------------
    sched_result_t  got_r;
    sched_result_t  want_r;
    int             stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                got_r.st   = status;
                got_r.nv   = next_valid;
                got_r.nt   = next_task;
                got_r.rs   = resched;
                got_r.cnt  = queued_count;
                got_r.wsum = queued_weight;
                got_r.sl   = slice_left;
                if (sched_want_q.size() == 0)
                    flag_mismatch($sformatf("item %0d with nothing expected", results_seen));
                else
                begin
                    want_r = sched_want_q.pop_front();
                    if (got_r.st !== want_r.st)
                        flag_mismatch($sformatf("item %0d status %0b want %0b",
                                                results_seen, got_r.st, want_r.st));
                    if (got_r.nv !== want_r.nv)
                        flag_mismatch($sformatf("item %0d next_valid %0b want %0b",
                                                results_seen, got_r.nv, want_r.nv));
                    if (got_r.nt !== want_r.nt)
                        flag_mismatch($sformatf("item %0d next_task %0d want %0d",
                                                results_seen, got_r.nt, want_r.nt));
                    if (got_r.rs !== want_r.rs)
                        flag_mismatch($sformatf("item %0d resched %0b want %0b",
                                                results_seen, got_r.rs, want_r.rs));
                    if (got_r.cnt !== want_r.cnt)
                        flag_mismatch($sformatf("item %0d queued_count %0d want %0d",
                                                results_seen, got_r.cnt, want_r.cnt));
                    if (got_r.wsum !== want_r.wsum)
                        flag_mismatch($sformatf("item %0d queued_weight %0d want %0d",
                                                results_seen, got_r.wsum, want_r.wsum));
                    if (got_r.sl !== want_r.sl)
                        flag_mismatch($sformatf("item %0d slice_left %0d want %0d",
                                                results_seen, got_r.sl, want_r.sl));
                end
            end
            // stall runs of random length, none during a burst stretch
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                stall_left = (!burst_now && $urandom_range(0, 3) == 0) ? rand_gap() : 0;
                out_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: work outstanding but nothing moving for too long
    // ------------------------------------------------------------------
    int stuck_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n && results_seen < items_issued && !(in_valid && !in_stall)
            && !(out_valid && !out_stall))
        begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("[%0t] no item moved for %0d cycles", $realtime, stuck_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
        else
            stuck_cycles = 0;
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed table, random phases, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t dir_tab [$];
        sched_op_t it;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: base slice 10, default weight 10
        // empty queue pick reports zeros
        dir_tab.push_back(row_chk(FN_PICK, 0, 0, row_want(0, 0, 0, 0, 0, 0, 0)));
        // zero weight takes the default register
        dir_tab.push_back(row_chk(FN_ADMIT, 0, 0, row_want(0, 0, 0, 0, 0, 0, 100)));
        dir_tab.push_back(row_chk(FN_ADMIT, 63, 255, row_want(0, 0, 0, 0, 0, 0, 2550)));
        dir_tab.push_back(row_chk(FN_ADMIT, 1, 1, row_want(0, 0, 0, 0, 0, 0, 10)));
        dir_tab.push_back(row_chk(FN_ENQ_TAIL, 0, 0, row_want(0, 1, 0, 0, 1, 10, 100)));
        dir_tab.push_back(row_chk(FN_ENQ_TAIL, 63, 0, row_want(0, 1, 0, 0, 2, 265, 2550)));
        dir_tab.push_back(row_chk(FN_ENQ_HEAD, 1, 0, row_want(0, 1, 1, 0, 3, 266, 10)));
        // enqueue of a task already queued is ignored
        dir_tab.push_back(row_chk(FN_ENQ_TAIL, 1, 0, row_want(1, 1, 1, 0, 3, 266, 10)));
        // re-admit while queued swaps the weight inside the sum
        dir_tab.push_back(row_chk(FN_ADMIT, 1, 3, row_want(0, 1, 1, 0, 3, 268, 30)));
        dir_tab.push_back(row_op(FN_YIELD, 1, 0));      // head moves to tail
        dir_tab.push_back(row_op(FN_TICK, 63, 0));
        dir_tab.push_back(row_op(FN_DEQUEUE, 63, 0));   // middle of the list
        dir_tab.push_back(row_op(FN_DEQUEUE, 63, 0));   // not queued
        dir_tab.push_back(row_op(FN_PICK, 0, 0));
        dir_tab.push_back(row_op(FN_YIELD, 0, 0));
        dir_tab.push_back(row_op(FN_UNUSED, 63, 0));
        dir_tab.push_back(row_op(FN_YIELD, 63, 0));     // yield of a task not queued
        // smallest slice: expiry on every tick
        dir_tab.push_back(row_cfg(REG_BASE_SLICE, 1));
        dir_tab.push_back(row_cfg(REG_DEFAULT_WEIGHT, 255));
        dir_tab.push_back(row_op(FN_ADMIT, 2, 0));
        dir_tab.push_back(row_op(FN_ADMIT, 3, 1));
        dir_tab.push_back(row_op(FN_TICK, 3, 0));       // expiry while not queued
        dir_tab.push_back(row_op(FN_ENQ_TAIL, 3, 0));
        dir_tab.push_back(row_op(FN_TICK, 3, 0));       // expiry of the tail task
        dir_tab.push_back(row_op(FN_ADMIT, 0, 1));
        dir_tab.push_back(row_op(FN_TICK, 0, 0));       // expiry requeues mid task
        // largest slice
        dir_tab.push_back(row_cfg(REG_BASE_SLICE, 1023));
        dir_tab.push_back(row_op(FN_ADMIT, 62, 255));
        dir_tab.push_back(row_op(FN_ENQ_HEAD, 62, 0));
        dir_tab.push_back(row_op(FN_PICK, 0, 0));

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                wait_idle();
                apb_write(dir_tab[i].reg_sel, dir_tab[i].reg_val);
            end
            else
            begin
                it = dir_tab[i].op;
                it.gap = rand_gap();
                push_item(it);
            end
        end

        // random phases across register settings, extremes first
        run_phase(1, 1, 6, 1'b0, 200);
        run_phase(1023, 255, 64, 1'b1, 250);
        run_phase($urandom_range(1, 1023), $urandom_range(1, 255), 16, 1'b0, 200);
        run_phase(2, 3, 64, 1'b1, 150);
        run_phase($urandom_range(1, 1023), $urandom_range(1, 255), 8, 1'b0, 150);

        wait_idle();
        if (sched_want_q.size() != 0)
            flag_mismatch($sformatf("%0d expected items never came", sched_want_q.size()));
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
